// ----- src/pprtt_pkg.sv -----
package pprtt_pkg;

   localparam int ROUND_W  = 17;
   localparam int COUNT_W  = 16;
   localparam int TIME_W   = 64;
   localparam int DELAY_W  = 32;
   localparam int ACTION_W = 2;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [ROUND_W-1:0] ROUND_FIRST = 17'd1;
   localparam logic [ROUND_W-1:0] ROUND_MAX   = 17'h1FFFF;

   localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PING = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SKIP = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_PONG = 2'd3;

   localparam logic [1:0] REG_WARMUP   = 2'd0;
   localparam logic [1:0] REG_MEASURED = 2'd1;
   localparam logic [1:0] REG_PACING   = 2'd2;
   localparam logic [1:0] REG_TIMEOUT  = 2'd3;

   typedef struct packed {
      logic [COUNT_W-1:0] warmup_count;
      logic [COUNT_W-1:0] measure_count;
      logic [DELAY_W-1:0] pacing_delay_ns;
      logic [DELAY_W-1:0] reply_timeout_ns;
   } cfg_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TIME_W-1:0]   time_ns;
      logic [ROUND_W-1:0]  pong_round;
   } req_type;

   typedef struct packed {
      logic                should_send;
      logic [ROUND_W-1:0]  send_round;
      logic                timed_out;
      logic                complete;
      logic                pong_accepted;
      logic                sample_valid;
      logic [TIME_W-1:0]   rtt_ns;
      logic [COUNT_W-1:0]  sample_index;
   } rsp_type;

endpackage

// ----- src/pprtt_csr.sv -----
module pprtt_csr
   import pprtt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       write_en;

   // Registers sit on word boundaries, so the low two address bits are ignored.
   assign reg_index  = csr_paddr[CSR_AW-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_WARMUP:   cfg_in.warmup_count     = csr_pwdata[COUNT_W-1:0];
            REG_MEASURED: cfg_in.measure_count    = csr_pwdata[COUNT_W-1:0];
            REG_PACING:   cfg_in.pacing_delay_ns  = csr_pwdata[DELAY_W-1:0];
            REG_TIMEOUT:  cfg_in.reply_timeout_ns = csr_pwdata[DELAY_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_WARMUP:   csr_prdata = {{(CSR_DW-COUNT_W){1'b0}}, cfg_ff.warmup_count};
         REG_MEASURED: csr_prdata = {{(CSR_DW-COUNT_W){1'b0}}, cfg_ff.measure_count};
         REG_PACING:   csr_prdata = cfg_ff.pacing_delay_ns;
         REG_TIMEOUT:  csr_prdata = cfg_ff.reply_timeout_ns;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/pprtt_core.sv -----
module pprtt_core
   import pprtt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   logic               awaiting_ff, awaiting_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [TIME_W-1:0]  send_time_ff, send_time_in;
   logic [TIME_W-1:0]  ping_time_ff, ping_time_in;
   logic [COUNT_W-1:0] samples_ff, samples_in;

   logic [ROUND_W-1:0] round_limit;
   logic [ROUND_W-1:0] round_step;
   logic [TIME_W-1:0]  elapsed;
   logic [TIME_W-1:0]  paced_time;
   logic               accept;
   logic               sample;
   logic               end_round;
   logic               late;

   assign round_limit = {1'b0, cfg.warmup_count} + {1'b0, cfg.measure_count};
   assign round_step  = (round_ff == ROUND_MAX) ? round_ff : round_ff + ROUND_FIRST;
   assign elapsed     = item.time_ns - ping_time_ff;
   assign paced_time  = item.time_ns + {{(TIME_W-DELAY_W){1'b0}}, cfg.pacing_delay_ns};

   assign accept    = (item.action == ACT_PONG) && awaiting_ff &&
                      (item.pong_round == round_ff);
   assign sample    = accept && (item.pong_round > {1'b0, cfg.warmup_count}) &&
                      (samples_ff < cfg.measure_count);
   assign end_round = (item.action == ACT_SKIP) || accept;

   always_comb begin
      awaiting_in  = awaiting_ff;
      round_in     = round_ff;
      send_time_in = send_time_ff;
      ping_time_in = ping_time_ff;
      samples_in   = samples_ff;
      unique case (item.action)
         ACT_TICK: begin
         end
         ACT_PING: begin
            awaiting_in  = 1'b1;
            ping_time_in = item.time_ns;
         end
         ACT_SKIP, ACT_PONG: begin
            if (end_round) begin
               awaiting_in  = 1'b0;
               round_in     = round_step;
               send_time_in = paced_time;
            end
            if (sample) begin
               samples_in = samples_ff + 16'd1;
            end
         end
      endcase
   end

   // A fresh ping leaves zero elapsed time, so only a zero timeout fires then.
   assign late = (item.action == ACT_PING) ? (cfg.reply_timeout_ns == '0)
               : (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, cfg.reply_timeout_ns});

   always_comb begin
      result.should_send   = !awaiting_in && (round_in <= round_limit) &&
                             (item.time_ns >= send_time_in);
      result.send_round    = round_in;
      result.timed_out     = awaiting_in && late;
      result.complete      = !awaiting_in && (round_in > round_limit);
      result.pong_accepted = accept;
      result.sample_valid  = sample;
      result.rtt_ns        = sample ? elapsed : '0;
      result.sample_index  = sample ? samples_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b0;
         round_ff     <= ROUND_FIRST;
         send_time_ff <= '0;
         ping_time_ff <= '0;
         samples_ff   <= '0;
      end else if (fire) begin
         awaiting_ff  <= awaiting_in;
         round_ff     <= round_in;
         send_time_ff <= send_time_in;
         ping_time_ff <= ping_time_in;
         samples_ff   <= samples_in;
      end
   end

endmodule

// ----- src/ping_pong_rtt_meter.sv -----
// A taken word moves from the input register to the result register (rsp_valid) on advance.
// Throughput: one word per cycle while rsp_stall is low, one round-state update per word.
// The input and result registers hold one word each; req_stall rises only when both are full.
// Reset is synchronous and active high; it clears the config registers, the round state
// (round counter back to one) and all valid flags. No clearing pass is needed.
module ping_pong_rtt_meter
   import pprtt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [TIME_W-1:0]   req_time_ns,
   input  logic [ROUND_W-1:0]  req_pong_round,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_should_send,
   output logic [ROUND_W-1:0]  rsp_send_round,
   output logic                rsp_timed_out,
   output logic                rsp_complete,
   output logic                rsp_pong_accepted,
   output logic                rsp_sample_valid,
   output logic [TIME_W-1:0]   rsp_rtt_ns,
   output logic [COUNT_W-1:0]  rsp_sample_index,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   cfg_type cfg;

   // The input register holds one word waiting to be evaluated against the state.
   logic    in_valid_ff;
   req_type in_word_ff;
   req_type in_word_in;

   // The result register holds the finished word until the consumer takes it.
   logic    out_valid_ff;
   rsp_type out_word_ff;
   rsp_type result;

   logic advance;
   logic fire;

   pprtt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The result register can take a new word when it is empty or being drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   // The input register stalls only when it is full and cannot move forward.
   assign req_stall = in_valid_ff && !advance;
   // The round state commits exactly when a word moves into the result register.
   assign fire      = in_valid_ff && advance;

   assign in_word_in.action     = req_action;
   assign in_word_in.time_ns    = req_time_ns;
   assign in_word_in.pong_round = req_pong_round;

   pprtt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (in_word_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // Payload registers carry no reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= in_word_in;
      end
      if (fire) begin
         out_word_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_should_send   = out_word_ff.should_send;
   assign rsp_send_round    = out_word_ff.send_round;
   assign rsp_timed_out     = out_word_ff.timed_out;
   assign rsp_complete      = out_word_ff.complete;
   assign rsp_pong_accepted = out_word_ff.pong_accepted;
   assign rsp_sample_valid  = out_word_ff.sample_valid;
   assign rsp_rtt_ns        = out_word_ff.rtt_ns;
   assign rsp_sample_index  = out_word_ff.sample_index;

endmodule

// ----- src/pprtt_checker.sv -----
module pprtt_checker
   import pprtt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_should_send,
   input  logic               rsp_timed_out,
   input  logic               rsp_complete,
   input  logic               rsp_pong_accepted,
   input  logic               rsp_sample_valid,
   input  logic [TIME_W-1:0]  rsp_rtt_ns,
   input  logic [COUNT_W-1:0] rsp_sample_index
);

   // A stalled result word stays on the port unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rtt_ns) &&
                                 $stable(rsp_sample_index))
      else $error("stalled result word changed");

   // A sample is only recorded by an accepted pong.
   a_sample_needs_pong: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_valid |-> rsp_pong_accepted)
      else $error("sample without accepted pong");

   // A finished run never asks for another ping.
   a_complete_no_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_complete |-> !rsp_should_send)
      else $error("send requested after completion");

   // A timeout implies a ping is outstanding, which excludes send and complete.
   a_timeout_awaiting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> !rsp_should_send && !rsp_complete)
      else $error("timeout reported while not awaiting");

   // Without a sample the measurement fields read zero.
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sample_valid |-> (rsp_rtt_ns == '0) && (rsp_sample_index == '0))
      else $error("measurement fields set without a sample");

endmodule

bind ping_pong_rtt_meter pprtt_checker u_pprtt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_should_send   (rsp_should_send),
   .rsp_timed_out     (rsp_timed_out),
   .rsp_complete      (rsp_complete),
   .rsp_pong_accepted (rsp_pong_accepted),
   .rsp_sample_valid  (rsp_sample_valid),
   .rsp_rtt_ns        (rsp_rtt_ns),
   .rsp_sample_index  (rsp_sample_index)
);

// ----- tb/testbench.sv -----
// Self-checking bench for the ping/pong round-trip-time meter.
//
// Every request word that the meter accepts is run through a local model of
// the round state (awaiting flag, next round, send time, pacing deadline and
// sample count). The model's status word is queued. Each response word that
// leaves the meter is compared field by field against the oldest queued word.
//
// The test tasks run in turn from one initial block. They share send_word,
// which offers one request word and updates the model when the word is taken,
// and set_config, which drains the meter and then rewrites all four registers
// over the APB-style port. Both channels idle at random, except during the
// full-rate stretch, which goes with no idling at all.
module testbench;
   import pprtt_pkg::*;

   // The limit leaves wide room for the whole run.
   localparam int CYCLE_LIMIT = 100_000;
   // Extra wait in settle; a taken word passes the input and result registers before it leaves.
   localparam int DRAIN_CYCLES = 6;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = ACT_TICK;
   logic [TIME_W-1:0]   req_time_ns = '0;
   logic [ROUND_W-1:0]  req_pong_round = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_should_send;
   logic [ROUND_W-1:0]  rsp_send_round;
   logic                rsp_timed_out;
   logic                rsp_complete;
   logic                rsp_pong_accepted;
   logic                rsp_sample_valid;
   logic [TIME_W-1:0]   rsp_rtt_ns;
   logic [COUNT_W-1:0]  rsp_sample_index;

   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // Model copy of the configuration registers.
   logic [COUNT_W-1:0]  cfg_warmup = '0;
   logic [COUNT_W-1:0]  cfg_measured = '0;
   logic [DELAY_W-1:0]  cfg_pacing = '0;
   logic [DELAY_W-1:0]  cfg_timeout = '0;

   // Model copy of the round state, as it stands after the last taken word.
   logic                rt_awaiting = 1'b0;
   logic [ROUND_W-1:0]  rt_next_round = ROUND_FIRST;
   logic [TIME_W-1:0]   rt_next_send = '0;
   logic [TIME_W-1:0]   rt_ping_time = '0;
   logic [COUNT_W-1:0]  rt_samples = '0;

   rsp_type pending_status[$];

   int  error_count = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  samples_seen = 0;
   int  configs_written = 0;
   int  cycle_count = 0;
   // Set while both sides are to run flat out, with no idle or stall cycles.
   bit  steady = 1'b0;

   ping_pong_rtt_meter DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_time_ns       (req_time_ns),
      .req_pong_round    (req_pong_round),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_should_send   (rsp_should_send),
      .rsp_send_round    (rsp_send_round),
      .rsp_timed_out     (rsp_timed_out),
      .rsp_complete      (rsp_complete),
      .rsp_pong_accepted (rsp_pong_accepted),
      .rsp_sample_valid  (rsp_sample_valid),
      .rsp_rtt_ns        (rsp_rtt_ns),
      .rsp_sample_index  (rsp_sample_index),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // A hung handshake or a lost response word ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles with %0d words still expected",
               cycle_count, pending_status.size());
      $display("Simulation FAILED");
      $finish;
   end

   // The response side stalls at random with a chance of 11 in a hundred.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 11);
   end

   // Ending a round, by a skip or by an accepted pong, clears the wait, moves
   // the round on and restarts the pacing delay from the event time. The round
   // counter holds at its top value rather than wrapping back to zero.
   function automatic void close_round(input logic [TIME_W-1:0] now);
      rt_awaiting = 1'b0;
      if (rt_next_round != ROUND_MAX) begin
         rt_next_round = rt_next_round + 1'b1;
      end
      rt_next_send = now + {32'd0, cfg_pacing};
   endfunction

   // Applies one event to the model round state and returns the status word
   // the meter must report for it. The status flags look at the state after
   // the event, at the event's own time. Time differences wrap modulo 2^64.
   function automatic rsp_type predict_round_status(input logic [ACTION_W-1:0] act,
                                                     input logic [TIME_W-1:0]   now,
                                                     input logic [ROUND_W-1:0]  pong);
      rsp_type            status;
      logic [ROUND_W-1:0] total;
      logic [TIME_W-1:0]  elapsed;
      status = '0;
      total = {1'b0, cfg_warmup} + {1'b0, cfg_measured};
      case (act)
         ACT_PING: begin
            // A ping while already waiting just moves the ping time.
            rt_ping_time = now;
            rt_awaiting = 1'b1;
         end
         ACT_SKIP: begin
            close_round(now);
         end
         ACT_PONG: begin
            // Stray pongs, or pongs nobody waits for, leave the state alone.
            if (rt_awaiting && pong == rt_next_round) begin
               status.pong_accepted = 1'b1;
               if (pong > {1'b0, cfg_warmup} && rt_samples < cfg_measured) begin
                  status.sample_valid = 1'b1;
                  status.rtt_ns = now - rt_ping_time;
                  status.sample_index = rt_samples;
                  rt_samples = rt_samples + 1'b1;
               end
               close_round(now);
            end
         end
         default: begin
            // A tick changes nothing; it only asks for the status.
         end
      endcase
      elapsed = now - rt_ping_time;
      status.should_send = !rt_awaiting && rt_next_round <= total && now >= rt_next_send;
      status.send_round = rt_next_round;
      status.timed_out = rt_awaiting && elapsed >= {32'd0, cfg_timeout};
      status.complete = !rt_awaiting && rt_next_round > total;
      return status;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("Field %s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Response checker: runs on every edge at which a response word is taken.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $error("Response word arrived with no prediction pending");
            error_count++;
         end else begin
            want = pending_status.pop_front();
            check_field("should_send", want.should_send, rsp_should_send);
            check_field("send_round", want.send_round, rsp_send_round);
            check_field("timed_out", want.timed_out, rsp_timed_out);
            check_field("complete", want.complete, rsp_complete);
            check_field("pong_accepted", want.pong_accepted, rsp_pong_accepted);
            check_field("sample_valid", want.sample_valid, rsp_sample_valid);
            check_field("rtt_ns", want.rtt_ns, rsp_rtt_ns);
            check_field("sample_index", want.sample_index, rsp_sample_index);
            words_checked++;
            if (want.sample_valid) begin
               samples_seen++;
            end
         end
      end
   end

   // Offers one request word and returns at the edge that takes it. Valid is
   // left high on return, so a word sent right after follows with no gap; a
   // random number of idle cycles may go first. The model steps only once the
   // word has really been taken.
   task automatic send_word(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] now,
                            input logic [ROUND_W-1:0] pong);
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_time_ns <= now;
      req_pong_round <= pong;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_status.push_back(predict_round_status(act, now, pong));
      words_sent++;
   endtask

   // Drops valid and waits until every expected word has come back, then waits
   // out DRAIN_CYCLES as well so that the meter is certainly idle.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: a setup cycle, an access cycle that completes on pready,
   // and an idle cycle after. A read compares prdata against the model value.
   task automatic csr_access(input logic write, input logic [1:0] index,
                             input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= CSR_AW'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      if (!write && csr_prdata !== value) begin
         $error("Register %0d read back: expected 0x%0h, got 0x%0h", index, value, csr_prdata);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [COUNT_W-1:0] warmup,
                             input logic [COUNT_W-1:0] measured,
                             input logic [DELAY_W-1:0] pacing,
                             input logic [DELAY_W-1:0] timeout);
      settle();
      csr_access(1'b1, REG_WARMUP, {16'd0, warmup});
      csr_access(1'b1, REG_MEASURED, {16'd0, measured});
      csr_access(1'b1, REG_PACING, pacing);
      csr_access(1'b1, REG_TIMEOUT, timeout);
      cfg_warmup = warmup;
      cfg_measured = measured;
      cfg_pacing = pacing;
      cfg_timeout = timeout;
      csr_access(1'b0, REG_WARMUP, {16'd0, warmup});
      csr_access(1'b0, REG_MEASURED, {16'd0, measured});
      csr_access(1'b0, REG_PACING, pacing);
      csr_access(1'b0, REG_TIMEOUT, timeout);
      configs_written++;
   endtask

   // Registers read zero after reset, and with no rounds configured the meter
   // reports itself complete. A pong that nobody waits for is ignored.
   task automatic test_reset_values();
      csr_access(1'b0, REG_WARMUP, '0);
      csr_access(1'b0, REG_MEASURED, '0);
      csr_access(1'b0, REG_PACING, '0);
      csr_access(1'b0, REG_TIMEOUT, '0);
      send_word(ACT_TICK, 64'd0, '0);
      send_word(ACT_PONG, 64'd3, ROUND_FIRST);
      settle();
   endtask

   // One warm-up round and two measured ones, walked through by hand: pacing,
   // the timeout edge, a stray pong, a repeated ping, a skip with nothing in
   // flight, a clock that runs backwards, pings after completion and times at
   // both ends of the 64-bit range.
   task automatic test_directed_rounds();
      set_config(16'd1, 16'd2, 32'd100, 32'd50);
      send_word(ACT_TICK, 64'd0, '0);
      send_word(ACT_PING, 64'd10, '0);
      send_word(ACT_TICK, 64'd59, '0);
      send_word(ACT_TICK, 64'd60, '0);
      send_word(ACT_PONG, 64'd61, 17'd2);
      send_word(ACT_PONG, 64'd70, 17'd1);
      send_word(ACT_TICK, 64'd169, '0);
      send_word(ACT_TICK, 64'd170, '0);
      send_word(ACT_PING, 64'd170, '0);
      send_word(ACT_PING, 64'd180, '0);
      send_word(ACT_PONG, 64'd200, 17'd2);
      send_word(ACT_SKIP, 64'd250, '0);
      send_word(ACT_PING, 64'd400, '0);
      send_word(ACT_PONG, 64'd399, 17'd4);
      send_word(ACT_PING, 64'd500, '0);
      send_word(ACT_PONG, 64'd510, 17'd5);
      send_word(ACT_SKIP, '1, '1);
      send_word(ACT_PING, '1, '0);
      send_word(ACT_TICK, 64'd0, '0);
      send_word(ACT_PONG, 64'd1, '0);
      send_word(ACT_PONG, 64'd2, ROUND_MAX);
      settle();
   endtask

   // Random rounds in seven phases, each under its own register setting. Most
   // of the traffic is well-formed rounds (ticks, a ping, ticks, then a pong
   // for the right round or a skip); the rest is stray pongs, repeated pings,
   // abandoned rounds and words with fully random fields.
   task automatic test_random_rounds();
      logic [TIME_W-1:0] now;
      int                issued;
      int                pick;
      for (int phase = 0; phase < 7; phase++) begin
         // Except in phase 0, which clears every register, warm-up and measured counts are set
         // relative to where the run stands or to their top value.
         case (phase)
            0: begin
               set_config('0, '0, '0, '0);
            end
            2: begin
               set_config(16'(rt_next_round - 1'b1 + ROUND_W'($urandom_range(0, 3))),
                          '1, '1, '1);
            end
            6: begin
               set_config('1, 16'(rt_samples + $urandom_range(5, 20)), '0, '0);
            end
            default: begin
               set_config(16'(rt_next_round - 1'b1 + ROUND_W'($urandom_range(0, 3))),
                          16'(rt_samples + $urandom_range(5, 20)),
                          32'($urandom_range(0, 200)), 32'($urandom_range(0, 300)));
            end
         endcase
         // Odd phases start anywhere in the 64-bit range, so times may wrap.
         now = (phase % 2 == 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 1000));
         issued = 0;
         while (issued < 85) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               send_word(ACTION_W'($urandom), {$urandom, $urandom}, ROUND_W'($urandom));
               issued++;
            end else begin
               repeat ($urandom_range(0, 2)) begin
                  now = now + 64'($urandom_range(0, 150));
                  send_word(ACT_TICK, now, ROUND_W'($urandom));
                  issued++;
               end
               now = now + 64'($urandom_range(0, 100));
               send_word(ACT_PING, now, ROUND_W'($urandom));
               issued++;
               if ($urandom_range(99) < 8) begin
                  now = now + 64'($urandom_range(0, 100));
                  send_word(ACT_PING, now, ROUND_W'($urandom));
                  issued++;
               end
               repeat ($urandom_range(0, 2)) begin
                  now = now + 64'($urandom_range(0, 150));
                  send_word(ACT_TICK, now, ROUND_W'($urandom));
                  issued++;
               end
               if ($urandom_range(99) < 10) begin
                  // The XOR with a nonzero value guarantees a wrong round number.
                  send_word(ACT_PONG, now + 64'($urandom_range(0, 50)),
                            rt_next_round ^ ROUND_W'($urandom_range(1, 131071)));
                  issued++;
               end
               now = now + 64'($urandom_range(0, 200));
               pick = $urandom_range(99);
               if (pick < 75) begin
                  send_word(ACT_PONG, now, rt_next_round);
                  issued++;
               end else if (pick < 95) begin
                  send_word(ACT_SKIP, now, ROUND_W'($urandom));
                  issued++;
               end
               // Otherwise the round is left hanging and the next ping replaces it.
            end
         end
      end
      settle();
   endtask

   // A long stretch with both sides running flat out: pings, pongs for the
   // right round, skips and ticks follow one per cycle, so every word meets
   // the round state that the word just before it left behind.
   task automatic test_full_rate_rounds();
      logic [TIME_W-1:0] now;
      int                pick;
      now = 64'd5000;
      set_config(16'(rt_next_round + ROUND_W'(1)), 16'(rt_samples + 30), 32'd3, 32'd4);
      steady = 1'b1;
      for (int n = 0; n < 80; n++) begin
         now = now + 64'($urandom_range(0, 4));
         pick = $urandom_range(99);
         if (pick < 60) begin
            if (rt_awaiting) begin
               send_word(ACT_PONG, now, rt_next_round);
            end else begin
               send_word(ACT_PING, now, ROUND_W'($urandom));
            end
         end else if (pick < 75) begin
            send_word(ACT_TICK, now, ROUND_W'($urandom));
         end else if (pick < 90) begin
            send_word(ACT_SKIP, now, ROUND_W'($urandom));
         end else begin
            send_word(ACT_PING, now, ROUND_W'($urandom));
         end
      end
      steady = 1'b0;
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_rounds();
      test_random_rounds();
      test_full_rate_rounds();
      settle();
      $display("Checked %0d response words for %0d request words, %0d of them RTT samples.",
               words_checked, words_sent, samples_seen);
      $display("Ran %0d register settings, one of them a full-rate stretch with no idling.",
               configs_written);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
